// ===== hdl/tsb_pkg.sv =====
// Shared types, constants and helper functions of the bilinear texture sampler.
package tsb_pkg;

    // Sizes
    localparam int MAX_DIM         = 256;
    localparam int COORD_FRAC_BITS = 16;
    localparam int WEIGHT_BITS     = 8;
    localparam int COORD_W         = 24;
    localparam int CHAN_W          = 8;
    localparam int TEXEL_W         = 3 * CHAN_W;
    localparam int ADDR_W          = 16;
    localparam int OUT_W           = 16;
    localparam int DIM_W           = $clog2(MAX_DIM + 1);
    localparam int IDX_W           = $clog2(MAX_DIM);
    localparam int UC_W            = COORD_FRAC_BITS + 1;
    localparam int PROD_W          = UC_W + DIM_W;
    localparam int ROW_W           = IDX_W + DIM_W;
    localparam int WONE_W          = WEIGHT_BITS + 1;
    localparam int ACC_W           = CHAN_W + WEIGHT_BITS;
    localparam int RES_W           = CHAN_W + 2 * WEIGHT_BITS + 1;
    localparam int RES_SH          = 2 * WEIGHT_BITS - 8;
    localparam int STORE_DEPTH     = 1 << ADDR_W;

    // Queue between front and back
    localparam int QDEPTH = 8;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Codes
    localparam logic OP_WRITE     = 1'b0;
    localparam logic OP_SAMPLE    = 1'b1;
    localparam logic FILT_NEAREST = 1'b0;
    localparam logic FILT_LINEAR  = 1'b1;
    localparam logic WRAP_CLAMP   = 1'b0;
    localparam logic WRAP_REPEAT  = 1'b1;

    // Register map (word index)
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FILTER = 2'd2;
    localparam logic [1:0] REG_WRAP   = 2'd3;

    localparam logic [OUT_W-1:0] MAGENTA_LEVEL = 16'hFF00;

    typedef struct packed {
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             filter;
        logic             wrap;
    } t_cfg;

    // One classified item on its way to the back end
    typedef struct packed {
        logic                   is_wr;
        logic                   nearest;
        logic                   err;
        logic [ADDR_W-1:0]      a00;
        logic [ADDR_W-1:0]      a10;
        logic [ADDR_W-1:0]      a01;
        logic [ADDR_W-1:0]      a11;
        logic [WEIGHT_BITS-1:0] wx;
        logic [WEIGHT_BITS-1:0] wy;
        logic [TEXEL_W-1:0]     wdata;
    } t_qitem;

    // Dimension with zero taken as one and oversize taken as the maximum
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end else begin
            r = d;
        end
        return r;
    endfunction

    // Clamp to [0,1] or keep the floor fraction
    function automatic logic [UC_W-1:0] shape_coord(input logic [COORD_W-1:0] c,
                                                    input logic wrap);
        logic [COORD_W-1:0] one_w;
        logic [UC_W-1:0]    r;
        one_w = COORD_W'(1) << COORD_FRAC_BITS;
        if (wrap == WRAP_REPEAT) begin
            r = {1'b0, c[COORD_FRAC_BITS-1:0]};
        end else if (c[COORD_W-1]) begin
            r = '0;
        end else if (c > one_w) begin
            r = UC_W'(1) << COORD_FRAC_BITS;
        end else begin
            r = c[UC_W-1:0];
        end
        return r;
    endfunction

    // Coordinate fraction cut down (or widened) to a blend weight
    function automatic logic [WEIGHT_BITS-1:0] frac_to_weight(
            input logic [COORD_FRAC_BITS-1:0] f);
        logic [COORD_FRAC_BITS+WEIGHT_BITS-1:0] t;
        t = {f, {WEIGHT_BITS{1'b0}}} >> COORD_FRAC_BITS;
        return t[WEIGHT_BITS-1:0];
    endfunction

endpackage

// ===== hdl/tsb_front.sv =====
// Front end: accepts items, shapes coordinates and works out texel addresses and weights.
module tsb_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  tsb_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_op,
    input  logic [15:0]     i_texel_index,
    input  logic [7:0]      i_red_in,
    input  logic [7:0]      i_green_in,
    input  logic [7:0]      i_blue_in,
    input  logic [23:0]     i_coord_u,
    input  logic [23:0]     i_coord_v,
    input  logic            i_pop,
    output logic            o_push,
    output tsb_pkg::t_qitem o_item
);

    logic [tsb_pkg::QCNT_W-1:0] r_credit, n_credit;
    logic                       accept;
    logic [tsb_pkg::DIM_W-1:0]  w_e, h_e, wm1, hm1, mx, my;

    // Stage 1: shaped coordinates
    logic                           r1_v, r1_op;
    logic [tsb_pkg::ADDR_W-1:0]     r1_idx;
    logic [tsb_pkg::TEXEL_W-1:0]    r1_rgb;
    logic [tsb_pkg::UC_W-1:0]       r1_u, r1_cv;
    // Stage 2: scaled coordinates
    logic                           r2_v, r2_op;
    logic [tsb_pkg::ADDR_W-1:0]     r2_idx;
    logic [tsb_pkg::TEXEL_W-1:0]    r2_rgb;
    logic [tsb_pkg::PROD_W-1:0]     r2_pu, r2_pv;
    // Stage 3: texel coordinates and weights
    logic                           r3_v, r3_op, r3_err;
    logic [tsb_pkg::ADDR_W-1:0]     r3_idx;
    logic [tsb_pkg::TEXEL_W-1:0]    r3_rgb;
    logic [tsb_pkg::IDX_W-1:0]      r3_x0, r3_x1, r3_y0, r3_y1;
    logic [tsb_pkg::WEIGHT_BITS-1:0] r3_wx, r3_wy;
    // Stage 4: row offsets
    logic                           r4_v, r4_op, r4_err;
    logic [tsb_pkg::ADDR_W-1:0]     r4_idx;
    logic [tsb_pkg::TEXEL_W-1:0]    r4_rgb;
    logic [tsb_pkg::IDX_W-1:0]      r4_x0, r4_x1;
    logic [tsb_pkg::ROW_W-1:0]      r4_y0w, r4_y1w;
    logic [tsb_pkg::WEIGHT_BITS-1:0] r4_wx, r4_wy;

    logic [tsb_pkg::DIM_W-1:0] xf, yf, x0c, y0c, x1c, y1c;

    assign w_e = tsb_pkg::eff_dim(i_cfg.width);
    assign h_e = tsb_pkg::eff_dim(i_cfg.height);
    assign wm1 = w_e - tsb_pkg::DIM_W'(1);
    assign hm1 = h_e - tsb_pkg::DIM_W'(1);
    assign mx  = (i_cfg.filter == tsb_pkg::FILT_LINEAR) ? wm1 : w_e;
    assign my  = (i_cfg.filter == tsb_pkg::FILT_LINEAR) ? hm1 : h_e;

    // Credits cover items in this pipeline and in the queue
    assign o_stall  = (r_credit == tsb_pkg::QCNT_W'(tsb_pkg::QDEPTH));
    assign accept   = i_valid && !o_stall;
    assign n_credit = r_credit + tsb_pkg::QCNT_W'(accept) - tsb_pkg::QCNT_W'(i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
        end else begin
            r_credit <= n_credit;
            r1_v     <= accept;
            r2_v     <= r1_v;
            r3_v     <= r2_v;
            r4_v     <= r3_v;
        end
    end

    // Texel coordinates: nearest clamps to the last texel, linear takes a neighbour
    // (integer part of the product is at most MAX_DIM, so DIM_W bits hold it)
    always_comb begin
        xf  = r2_pu[tsb_pkg::COORD_FRAC_BITS+tsb_pkg::DIM_W-1:tsb_pkg::COORD_FRAC_BITS];
        yf  = r2_pv[tsb_pkg::COORD_FRAC_BITS+tsb_pkg::DIM_W-1:tsb_pkg::COORD_FRAC_BITS];
        x0c = xf;
        y0c = yf;
        if (i_cfg.filter == tsb_pkg::FILT_NEAREST) begin
            if (xf > wm1) x0c = wm1;
            if (yf > hm1) y0c = hm1;
        end
        x1c = (x0c + tsb_pkg::DIM_W'(1) < wm1) ? x0c + tsb_pkg::DIM_W'(1) : wm1;
        y1c = (y0c + tsb_pkg::DIM_W'(1) < hm1) ? y0c + tsb_pkg::DIM_W'(1) : hm1;
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        r1_op  <= i_op;
        r1_idx <= i_texel_index;
        r1_rgb <= {i_red_in, i_green_in, i_blue_in};
        r1_u   <= tsb_pkg::shape_coord(i_coord_u, i_cfg.wrap);
        r1_cv  <= tsb_pkg::shape_coord(i_coord_v, i_cfg.wrap);

        r2_op  <= r1_op;
        r2_idx <= r1_idx;
        r2_rgb <= r1_rgb;
        r2_pu  <= tsb_pkg::PROD_W'(r1_u * mx);
        r2_pv  <= tsb_pkg::PROD_W'(r1_cv * my);

        r3_op  <= r2_op;
        r3_idx <= r2_idx;
        r3_rgb <= r2_rgb;
        r3_x0  <= x0c[tsb_pkg::IDX_W-1:0];
        r3_y0  <= y0c[tsb_pkg::IDX_W-1:0];
        r3_x1  <= x1c[tsb_pkg::IDX_W-1:0];
        r3_y1  <= y1c[tsb_pkg::IDX_W-1:0];
        r3_wx  <= tsb_pkg::frac_to_weight(r2_pu[tsb_pkg::COORD_FRAC_BITS-1:0]);
        r3_wy  <= tsb_pkg::frac_to_weight(r2_pv[tsb_pkg::COORD_FRAC_BITS-1:0]);
        r3_err <= (i_cfg.filter == tsb_pkg::FILT_LINEAR) &&
                  (w_e == tsb_pkg::DIM_W'(1) || h_e == tsb_pkg::DIM_W'(1));

        r4_op  <= r3_op;
        r4_idx <= r3_idx;
        r4_rgb <= r3_rgb;
        r4_err <= r3_err;
        r4_x0  <= r3_x0;
        r4_x1  <= r3_x1;
        r4_wx  <= r3_wx;
        r4_wy  <= r3_wy;
        r4_y0w <= tsb_pkg::ROW_W'(r3_y0 * w_e);
        r4_y1w <= tsb_pkg::ROW_W'(r3_y1 * w_e);
    end

    // Item for the queue
    always_comb begin
        o_push         = r4_v;
        o_item.is_wr   = (r4_op == tsb_pkg::OP_WRITE);
        o_item.nearest = (i_cfg.filter == tsb_pkg::FILT_NEAREST);
        o_item.err     = r4_err;
        o_item.a00     = tsb_pkg::ADDR_W'(r4_y0w + tsb_pkg::ROW_W'(r4_x0));
        o_item.a10     = tsb_pkg::ADDR_W'(r4_y0w + tsb_pkg::ROW_W'(r4_x1));
        o_item.a01     = tsb_pkg::ADDR_W'(r4_y1w + tsb_pkg::ROW_W'(r4_x0));
        o_item.a11     = tsb_pkg::ADDR_W'(r4_y1w + tsb_pkg::ROW_W'(r4_x1));
        o_item.wx      = r4_wx;
        o_item.wy      = r4_wy;
        o_item.wdata   = r4_rgb;
        if (r4_op == tsb_pkg::OP_WRITE) begin
            o_item.a00 = r4_idx;
        end
    end

endmodule

// ===== hdl/tsb_queue.sv =====
// Short item queue between the front and back ends.
module tsb_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tsb_pkg::t_qitem i_item,
    input  logic            i_pop,
    output logic            o_empty,
    output tsb_pkg::t_qitem o_item
);

    tsb_pkg::t_qitem            r_buf [tsb_pkg::QDEPTH];
    logic [tsb_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [tsb_pkg::QCNT_W-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_item  = r_buf[r_rptr];

    // Pointers and fill level; the front's credits keep it from overflowing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + tsb_pkg::QPTR_W'(1);
            if (i_pop)  r_rptr <= r_rptr + tsb_pkg::QPTR_W'(1);
            r_count <= r_count + tsb_pkg::QCNT_W'(i_push) - tsb_pkg::QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_buf[r_wptr] <= i_item;
    end

endmodule

// ===== hdl/tsb_back.sv =====
// Back end: texel store, four-texel fetch, bilinear blend and result register.
module tsb_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  tsb_pkg::t_qitem i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output logic [15:0]     o_red_out,
    output logic [15:0]     o_green_out,
    output logic [15:0]     o_blue_out,
    output logic            o_size_error
);

    // Two copies of the store, two read ports each: four texels per clock
    logic [tsb_pkg::TEXEL_W-1:0] mem_a [tsb_pkg::STORE_DEPTH];
    logic [tsb_pkg::TEXEL_W-1:0] mem_b [tsb_pkg::STORE_DEPTH];

    logic en;

    // Fetch stage
    logic                            r1_v, r1_near, r1_err;
    logic [tsb_pkg::WEIGHT_BITS-1:0] r1_wx, r1_wy;
    logic [tsb_pkg::TEXEL_W-1:0]     r_c00, r_c10, r_c01, r_c11;
    // Horizontal blend stage
    logic                            r2_v, r2_near, r2_err;
    logic [tsb_pkg::WEIGHT_BITS-1:0] r2_wy;
    logic [tsb_pkg::TEXEL_W-1:0]     r2_c00;
    logic [tsb_pkg::ACC_W-1:0]       r2_a [3];
    logic [tsb_pkg::ACC_W-1:0]       r2_b [3];
    // Result register
    logic                            r_ov, r_err;
    logic [tsb_pkg::OUT_W-1:0]       r_out [3];

    logic [tsb_pkg::WONE_W-1:0]  wx_i, wx_c, wy_i, wy_c;
    logic [tsb_pkg::ACC_W-1:0]   n_a [3];
    logic [tsb_pkg::ACC_W-1:0]   n_b [3];
    logic [tsb_pkg::OUT_W-1:0]   n_out [3];
    logic [tsb_pkg::RES_W-1:0]   res [3];

    // Whole pipeline moves unless a result is held up
    assign en    = !(r_ov && i_stall);
    assign o_pop = en && !i_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r_ov <= 1'b0;
        end else if (en) begin
            r1_v <= o_pop && !i_item.is_wr;
            r2_v <= r1_v;
            r_ov <= r2_v;
        end
    end

    // Store write and four registered reads
    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.is_wr) begin
            mem_a[i_item.a00] <= i_item.wdata;
            mem_b[i_item.a00] <= i_item.wdata;
        end
        if (en) begin
            r_c00 <= mem_a[i_item.a00];
            r_c10 <= mem_a[i_item.a10];
            r_c01 <= mem_b[i_item.a01];
            r_c11 <= mem_b[i_item.a11];
        end
    end

    // Weights and their complements
    assign wx_i = tsb_pkg::WONE_W'(r1_wx);
    assign wx_c = (tsb_pkg::WONE_W'(1) << tsb_pkg::WEIGHT_BITS) - wx_i;
    assign wy_i = tsb_pkg::WONE_W'(r2_wy);
    assign wy_c = (tsb_pkg::WONE_W'(1) << tsb_pkg::WEIGHT_BITS) - wy_i;

    // Per-channel blend: horizontal, then vertical
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_a[k] = tsb_pkg::ACC_W'(
                r_c00[tsb_pkg::TEXEL_W-1-tsb_pkg::CHAN_W*k -: tsb_pkg::CHAN_W] * wx_c +
                r_c10[tsb_pkg::TEXEL_W-1-tsb_pkg::CHAN_W*k -: tsb_pkg::CHAN_W] * wx_i);
            n_b[k] = tsb_pkg::ACC_W'(
                r_c01[tsb_pkg::TEXEL_W-1-tsb_pkg::CHAN_W*k -: tsb_pkg::CHAN_W] * wx_c +
                r_c11[tsb_pkg::TEXEL_W-1-tsb_pkg::CHAN_W*k -: tsb_pkg::CHAN_W] * wx_i);
            res[k] = tsb_pkg::RES_W'(r2_a[k] * wy_c + r2_b[k] * wy_i);
            if (r2_err) begin
                n_out[k] = (k == 1) ? '0 : tsb_pkg::MAGENTA_LEVEL;
            end else if (r2_near) begin
                n_out[k] = {r2_c00[tsb_pkg::TEXEL_W-1-tsb_pkg::CHAN_W*k -: tsb_pkg::CHAN_W],
                            {(tsb_pkg::OUT_W-tsb_pkg::CHAN_W){1'b0}}};
            end else begin
                n_out[k] = res[k][tsb_pkg::RES_SH+tsb_pkg::OUT_W-1:tsb_pkg::RES_SH];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_near <= i_item.nearest;
            r1_err  <= i_item.err && !i_item.nearest;
            r1_wx   <= i_item.wx;
            r1_wy   <= i_item.wy;

            r2_near <= r1_near;
            r2_err  <= r1_err;
            r2_wy   <= r1_wy;
            r2_c00  <= r_c00;
            r2_a    <= n_a;
            r2_b    <= n_b;

            r_err   <= r2_err;
            r_out   <= n_out;
        end
    end

    assign o_valid      = r_ov;
    assign o_red_out    = r_out[0];
    assign o_green_out  = r_out[1];
    assign o_blue_out   = r_out[2];
    assign o_size_error = r_err;

endmodule

// ===== hdl/texture_sampler_bilinear.sv =====
// Top level of the bilinear texture sampler: register port and front/queue/back hookup.
//
// Takes one item per clock while o_stall is low and returns one result per sample item. A write
// item (op 0) stores an RGB texel at texel_index; a sample item (op 1) returns the nearest or
// bilinearly blended texel, channels in texel units times 256, with size_error set and
// magenta returned when bilinear filtering meets a width or height of one. An item passes
// through four front stages (coordinate shaping, scale multiply, texel position, row
// offset), the queue, and three back stages (store read, horizontal blend, vertical blend
// into the result register). The four texel reads come from two copies of the 64K-entry
// store with two read ports each. A write is seen by every sample accepted after it.
// Texels never written read as undefined; there is no clearing pass. Registers (byte
// address): 0x0 width, 0x4 height, 0x8 filter mode (1 bilinear), 0xC wrap mode (1 repeat);
// change them only while the block is idle.
module texture_sampler_bilinear (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input items
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [15:0] i_texel_index,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [23:0] i_coord_u,
    input  logic [23:0] i_coord_v,
    // Result items
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_red_out,
    output logic [15:0] o_green_out,
    output logic [15:0] o_blue_out,
    output logic        o_size_error
);

    tsb_pkg::t_cfg   r_cfg;
    tsb_pkg::t_qitem push_item, pop_item;
    logic            push, pop, q_empty, wr_en;

    // Register writes
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width  <= tsb_pkg::DIM_W'(1);
            r_cfg.height <= tsb_pkg::DIM_W'(1);
            r_cfg.filter <= tsb_pkg::FILT_NEAREST;
            r_cfg.wrap   <= tsb_pkg::WRAP_CLAMP;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                tsb_pkg::REG_WIDTH:  r_cfg.width  <= pwdata[tsb_pkg::DIM_W-1:0];
                tsb_pkg::REG_HEIGHT: r_cfg.height <= pwdata[tsb_pkg::DIM_W-1:0];
                tsb_pkg::REG_FILTER: r_cfg.filter <= pwdata[0];
                tsb_pkg::REG_WRAP:   r_cfg.wrap   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register reads
    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            tsb_pkg::REG_WIDTH:  prdata = 32'(r_cfg.width);
            tsb_pkg::REG_HEIGHT: prdata = 32'(r_cfg.height);
            tsb_pkg::REG_FILTER: prdata = 32'(r_cfg.filter);
            tsb_pkg::REG_WRAP:   prdata = 32'(r_cfg.wrap);
            default:             prdata = '0;
        endcase
    end

    tsb_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_texel_index (i_texel_index),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .i_coord_u     (i_coord_u),
        .i_coord_v     (i_coord_v),
        .i_pop         (pop),
        .o_push        (push),
        .o_item        (push_item)
    );

    tsb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_item  (pop_item)
    );

    tsb_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_item       (pop_item),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_red_out    (o_red_out),
        .o_green_out  (o_green_out),
        .o_blue_out   (o_blue_out),
        .o_size_error (o_size_error)
    );

endmodule

// ===== verif/tsb_checker.sv =====
// Scoreboard of the bilinear texture sampler: predicts each sampled colour and checks results.
`timescale 1ns / 1ps

module tsb_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    // Input items
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic        i_op,
    input  logic [15:0] i_texel_index,
    input  logic [7:0]  i_red_in,
    input  logic [7:0]  i_green_in,
    input  logic [7:0]  i_blue_in,
    input  logic [23:0] i_coord_u,
    input  logic [23:0] i_coord_v,
    // Result items
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  logic [15:0] i_red_out,
    input  logic [15:0] i_green_out,
    input  logic [15:0] i_blue_out,
    input  logic        i_size_error,
    // Status towards the top
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic        err;
    } t_colour;

    logic [tsb_pkg::TEXEL_W-1:0] texels [tsb_pkg::STORE_DEPTH];
    logic [8:0]         width_reg;
    logic [8:0]         height_reg;
    logic               filter_reg;
    logic               wrap_reg;
    t_colour            expected_colours [$];
    int                 mismatches;

    assign o_fail_count = mismatches;
    assign o_pending    = expected_colours.size();

    // Zero counts as one, anything over the maximum as the maximum
    function automatic int clip_dim(logic [8:0] d);
        if (d == 0) return 1;
        if (d > tsb_pkg::MAX_DIM) return tsb_pkg::MAX_DIM;
        return int'(d);
    endfunction

    // Coordinate into [0, 1.0] in 16-bit fraction units
    function automatic int unit_coord(logic [23:0] c);
        int s;
        s = int'(signed'(c));
        if (wrap_reg == tsb_pkg::WRAP_REPEAT) return int'(c[15:0]);
        if (s < 0) return 0;
        if (s > 65536) return 65536;
        return s;
    endfunction

    function automatic logic [7:0] chan(logic [23:0] t, int k);
        return t[23 - 8*k -: 8];
    endfunction

    function automatic t_colour filter_texels(logic [23:0] cu, logic [23:0] cv);
        t_colour res;
        int w, h, u, v, x0, y0, x1, y1, fx, fy, wx, wy, a, b, r;
        logic [23:0] c00, c10, c01, c11;
        w = clip_dim(width_reg);
        h = clip_dim(height_reg);
        u = unit_coord(cu);
        v = unit_coord(cv);
        res = '0;
        if (filter_reg == tsb_pkg::FILT_NEAREST) begin
            x0 = (u * w) >>> 16;
            y0 = (v * h) >>> 16;
            if (x0 > w - 1) x0 = w - 1;
            if (y0 > h - 1) y0 = h - 1;
            c00 = texels[(y0 * w + x0) & 16'hFFFF];
            res.red   = {chan(c00, 0), 8'h00};
            res.green = {chan(c00, 1), 8'h00};
            res.blue  = {chan(c00, 2), 8'h00};
        end else if (w <= 1 || h <= 1) begin
            // degenerate texture in bilinear mode gives magenta
            res.red   = tsb_pkg::MAGENTA_LEVEL;
            res.blue  = tsb_pkg::MAGENTA_LEVEL;
            res.err   = 1'b1;
        end else begin
            fx = u * (w - 1);
            fy = v * (h - 1);
            x0 = fx >>> 16;
            y0 = fy >>> 16;
            x1 = (x0 + 1 < w - 1) ? x0 + 1 : w - 1;
            y1 = (y0 + 1 < h - 1) ? y0 + 1 : h - 1;
            wx = (fx & 16'hFFFF) >>> 8;
            wy = (fy & 16'hFFFF) >>> 8;
            c00 = texels[(y0 * w + x0) & 16'hFFFF];
            c10 = texels[(y0 * w + x1) & 16'hFFFF];
            c01 = texels[(y1 * w + x0) & 16'hFFFF];
            c11 = texels[(y1 * w + x1) & 16'hFFFF];
            for (int k = 0; k < 3; k++) begin
                a = chan(c00, k) * (256 - wx) + chan(c10, k) * wx;
                b = chan(c01, k) * (256 - wx) + chan(c11, k) * wx;
                r = ((a * (256 - wy) + b * wy) >>> 8) & 16'hFFFF;
                if (k == 0) res.red = r[15:0];
                else if (k == 1) res.green = r[15:0];
                else res.blue = r[15:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // Registers, store and expectations follow the accepted traffic
    always @(posedge i_clk) begin
        t_colour want;
        if (!i_rst_n) begin
            width_reg  <= 9'd1;
            height_reg <= 9'd1;
            filter_reg <= tsb_pkg::FILT_NEAREST;
            wrap_reg   <= tsb_pkg::WRAP_CLAMP;
            expected_colours.delete();
            mismatches = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    tsb_pkg::REG_WIDTH:  width_reg  <= pwdata[8:0];
                    tsb_pkg::REG_HEIGHT: height_reg <= pwdata[8:0];
                    tsb_pkg::REG_FILTER: filter_reg <= pwdata[0];
                    tsb_pkg::REG_WRAP:   wrap_reg   <= pwdata[0];
                endcase
            end
            if (i_valid && !i_stall_in) begin
                if (i_op == tsb_pkg::OP_WRITE) begin
                    texels[i_texel_index] = {i_red_in, i_green_in, i_blue_in};
                end else begin
                    expected_colours.push_back(filter_texels(i_coord_u, i_coord_v));
                end
            end
            if (i_res_valid && !i_res_stall) begin
                if (expected_colours.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_colours.pop_front();
                    if (i_red_out != want.red) report_mismatch("red", i_red_out, want.red);
                    if (i_green_out != want.green)
                        report_mismatch("green", i_green_out, want.green);
                    if (i_blue_out != want.blue) report_mismatch("blue", i_blue_out, want.blue);
                    if (i_size_error != want.err)
                        report_mismatch("size_error", i_size_error, want.err);
                end
            end
        end
    end

endmodule

// ===== verif/texture_sampler_bilinear_tb.sv =====
// Testbench top of the bilinear texture sampler: clock, stimulus, idling and verdict.
`timescale 1ns / 1ps

module texture_sampler_bilinear_tb;

    localparam int NUM_PHASES     = 12;
    localparam int PRESSURE_PHASE = 11;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int RANDOM_PER_PH  = 18;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_op = tsb_pkg::OP_WRITE;
    logic [15:0] i_texel_index = '0;
    logic [7:0]  i_red_in = '0, i_green_in = '0, i_blue_in = '0;
    logic [23:0] i_coord_u = '0, i_coord_v = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [15:0] o_red_out, o_green_out, o_blue_out;
    logic        o_size_error;

    int          fail_count, pending;
    int          idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
    int          phase = 0;
    int          quiet_cycles = 0;
    bit          texel_written [tsb_pkg::STORE_DEPTH];

    always #4 i_clk = ~i_clk;

    texture_sampler_bilinear DUT (.*);

    tsb_checker u_checker (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .i_valid, .i_stall_in(o_stall), .i_op, .i_texel_index,
        .i_red_in, .i_green_in, .i_blue_in, .i_coord_u, .i_coord_v,
        .i_res_valid(o_valid), .i_res_stall(i_stall),
        .i_red_out(o_red_out), .i_green_out(o_green_out), .i_blue_out(o_blue_out),
        .i_size_error(o_size_error),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Receiver: random stalls, plus one long hold-off in the pressure phase
    always @(posedge i_clk) begin
        static int hold_left = 0;
        static bit hold_done = 0;
        if (phase == PRESSURE_PHASE && !hold_done) begin
            hold_done = 1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (idle_mode == 2) begin
            i_stall <= ($urandom_range(99) < 77);
        end else if (idle_mode == 3) begin
            i_stall <= ($urandom_range(99) < 29);
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no traffic on either channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic reg_write(logic [1:0] idx, logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // One item on the input channel, with optional idle gap before it
    task automatic send_item(logic op, logic [15:0] idx, logic [23:0] rgb,
                             logic [23:0] cu, logic [23:0] cv);
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 77 : (idle_mode == 3) ? 29 : 0;
        if ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_texel_index <= idx;
        {i_red_in, i_green_in, i_blue_in} <= rgb;
        i_coord_u     <= cu;
        i_coord_v     <= cv;
        do @(posedge i_clk); while (o_stall);
        if (op == tsb_pkg::OP_WRITE) texel_written[idx] = 1;
    endtask

    task automatic write_texel(logic [15:0] idx);
        send_item(tsb_pkg::OP_WRITE, idx, 24'($urandom), 24'($urandom), 24'($urandom));
    endtask

    task automatic sample_at(logic [23:0] cu, logic [23:0] cv);
        send_item(tsb_pkg::OP_SAMPLE, 16'($urandom), 24'($urandom), cu, cv);
    endtask

    function automatic logic [23:0] pick_coord();
        case ($urandom_range(5))
            0: return 24'($urandom);
            1: return 24'($urandom_range(65536));
            2: return 24'(65536 + $urandom_range(3) - 1);
            3: return 24'(-int'($urandom_range(70000)));
            4: return 24'($urandom_range(127) * 65536 + $urandom_range(65535));
            default: return 24'($urandom_range(3) * 16384);
        endcase
    endfunction

    // Corner coordinates: zero, one, just above one, negative, field extremes, half, just under one
    task automatic corner_samples();
        logic [23:0] corners [8];
        corners = '{24'h000000, 24'h010000, 24'h010001, 24'hFFFFFF,
                    24'h7FFFFF, 24'h800000, 24'h008000, 24'h00FFFF};
        for (int k = 0; k < 8; k++) sample_at(corners[k], corners[7 - k]);
    endtask

    initial begin
        int ph_w [NUM_PHASES] = '{1, 4, 4, 256, 2, 1, 16, 7, 0, 511, 13, 2};
        int ph_h [NUM_PHASES] = '{1, 4, 4, 2, 256, 8, 1, 5, 3, 2, 11, 2};
        logic ph_f [NUM_PHASES] = '{tsb_pkg::FILT_NEAREST, tsb_pkg::FILT_LINEAR,
                                    tsb_pkg::FILT_LINEAR, tsb_pkg::FILT_LINEAR,
                                    tsb_pkg::FILT_NEAREST, tsb_pkg::FILT_LINEAR,
                                    tsb_pkg::FILT_LINEAR, tsb_pkg::FILT_NEAREST,
                                    tsb_pkg::FILT_LINEAR, tsb_pkg::FILT_NEAREST,
                                    tsb_pkg::FILT_LINEAR, tsb_pkg::FILT_LINEAR};
        logic ph_r [NUM_PHASES] = '{tsb_pkg::WRAP_CLAMP, tsb_pkg::WRAP_CLAMP,
                                    tsb_pkg::WRAP_REPEAT, tsb_pkg::WRAP_REPEAT,
                                    tsb_pkg::WRAP_CLAMP, tsb_pkg::WRAP_CLAMP,
                                    tsb_pkg::WRAP_REPEAT, tsb_pkg::WRAP_REPEAT,
                                    tsb_pkg::WRAP_CLAMP, tsb_pkg::WRAP_REPEAT,
                                    tsb_pkg::WRAP_CLAMP, tsb_pkg::WRAP_REPEAT};
        int w, h, area;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int p = 0; p < NUM_PHASES; p++) begin
            // registers only change once the pipe has drained
            i_valid <= 1'b0;
            while (pending != 0) @(posedge i_clk);
            repeat (16) @(posedge i_clk);
            reg_write(tsb_pkg::REG_WIDTH, 32'(ph_w[p]));
            reg_write(tsb_pkg::REG_HEIGHT, 32'(ph_h[p]));
            reg_write(tsb_pkg::REG_FILTER, 32'(ph_f[p]));
            reg_write(tsb_pkg::REG_WRAP, 32'(ph_r[p]));
            @(posedge i_clk);
            phase     = p;
            idle_mode = (p == PRESSURE_PHASE) ? 0 : p % 4;
            w = (ph_w[p] == 0) ? 1 : (ph_w[p] > tsb_pkg::MAX_DIM) ? tsb_pkg::MAX_DIM : ph_w[p];
            h = (ph_h[p] == 0) ? 1 : (ph_h[p] > tsb_pkg::MAX_DIM) ? tsb_pkg::MAX_DIM : ph_h[p];
            area = w * h;

            // every texel the phase can touch gets a value first
            for (int a = 0; a < area; a++) if (!texel_written[a]) write_texel(16'(a));
            if (p == 0) begin
                send_item(tsb_pkg::OP_WRITE, 16'hFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h800000);
                send_item(tsb_pkg::OP_WRITE, 16'h0000, 24'h000000, 24'h800000, 24'h7FFFFF);
                send_item(tsb_pkg::OP_WRITE, 16'h0000, 24'hFFFFFF, 24'h0, 24'h0);
            end
            if (p == 1 || p == 3) corner_samples();

            for (int n = 0; n < RANDOM_PER_PH; n++) begin
                if ($urandom_range(99) < 30) begin
                    if ($urandom_range(9) < 8) write_texel(16'($urandom_range(area - 1)));
                    else write_texel(16'($urandom));
                end else begin
                    sample_at(pick_coord(), pick_coord());
                end
            end
        end

        i_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
